>>> rtl/core/rhc_pkg.sv
// Package for the RGB to HSV color classifier: widths, constants, codes,
// configuration and pipeline structs, hue compare helpers. No dependencies.
package rhc_pkg;

  // Channel and payload widths
  localparam int RAW_W      = 10;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 14;
  // 1023 * 0xFFFF >> 14 is at most 4091, so a scaled channel never reaches
  // the 65535 ceiling and fits in 12 bits.
  localparam int CH_W       = RAW_W + GAIN_W - GAIN_FRAC;
  localparam int VAL_W      = 16;
  localparam int SAT_W      = 11;
  localparam int SAT_FRAC   = 10;
  localparam int QUO_W      = 13;                // hue quotient, 0..5759
  localparam int DVD_W      = CH_W + QUO_W;      // divider dividend
  localparam int NUM_W      = DVD_W + 2;         // signed hue numerator work width
  localparam int DEG_W      = 9;
  localparam int HUE_THR_W  = DEG_W + 5;         // 16 * degrees, with headroom
  localparam int CLS_W      = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Hue numerator constants, in sixteenths of a degree
  localparam logic signed [NUM_W-1:0] HUE_SPAN      = NUM_W'(960);   // 60 deg
  localparam logic signed [NUM_W-1:0] HUE_GREEN_OFS = NUM_W'(1920);  // 120 deg
  localparam logic signed [NUM_W-1:0] HUE_BLUE_OFS  = NUM_W'(3840);  // 240 deg
  localparam logic signed [NUM_W-1:0] HUE_FULL      = NUM_W'(5760);  // 360 deg

  // Black hue window for arena mode
  localparam int BLACK_HUE_CENTER     = 125;
  localparam int BLACK_HUE_HALF_WIDTH = 30;
  localparam int BLACK_HUE_LO         = BLACK_HUE_CENTER - BLACK_HUE_HALF_WIDTH;
  localparam int BLACK_HUE_HI         = BLACK_HUE_CENTER + BLACK_HUE_HALF_WIDTH;
  localparam logic BLACK_LO_NEG = (BLACK_HUE_LO < 0);
  localparam logic [HUE_THR_W-1:0] BLACK_THR_LO =
      HUE_THR_W'((BLACK_HUE_LO < 0) ? 0 : BLACK_HUE_LO * 16);
  localparam logic [HUE_THR_W-1:0] BLACK_THR_HI = HUE_THR_W'(BLACK_HUE_HI * 16);

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(16'h4000);

  typedef enum logic [CLS_W-1:0] {
    CLS_WHITE   = 3'd0,
    CLS_BLACK   = 3'd1,
    CLS_OUTSIDE = 3'd2,
    CLS_RED     = 3'd3,
    CLS_GREEN   = 3'd4,
    CLS_YELLOW  = 3'd5,
    CLS_NONE    = 3'd6
  } color_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARENA_MODE   = 3'd0,
    REG_RGB_GAINS    = 3'd1,
    REG_WHITE_LIMITS = 3'd2,
    REG_BLACK_VMAX   = 3'd3,
    REG_BLACK_VMIN   = 3'd4,
    REG_RED_HUE      = 3'd5,
    REG_GREEN_HUE    = 3'd6,
    REG_YELLOW_HUE   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } hue_sector_t;

  typedef struct packed {
    logic              arena_mode;
    logic [GAIN_W-1:0] gain_red;
    logic [GAIN_W-1:0] gain_green;
    logic [GAIN_W-1:0] gain_blue;
    logic [SAT_W-1:0]  white_sat_max;
    logic [VAL_W-1:0]  white_value_min;
    logic [VAL_W-1:0]  black_value_max;
    logic [VAL_W-1:0]  black_value_min;
    logic [DEG_W-1:0]  red_lo;
    logic [DEG_W-1:0]  red_hi;
    logic [DEG_W-1:0]  green_lo;
    logic [DEG_W-1:0]  green_hi;
    logic [DEG_W-1:0]  yellow_lo;
    logic [DEG_W-1:0]  yellow_hi;
  } cfg_t;

  // Register values after reset: unity gains, everything else zero
  localparam cfg_t CFG_RESET = '{gain_red:   GAIN_UNITY,
                                 gain_green: GAIN_UNITY,
                                 gain_blue:  GAIN_UNITY,
                                 default:    '0};

  // One lane of the restoring divider: partial remainder, dividend bits
  // not yet consumed (MSB first) and quotient bits produced so far.
  typedef struct packed {
    logic [CH_W-1:0]  den;
    logic [CH_W-1:0]  rem;
    logic [QUO_W-1:0] dvd;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic            valid;
    div_lane_t       hue;
    div_lane_t       sat;
    logic [CH_W-1:0] value;
  } div_stage_t;

  // 16 * degrees, as a compare threshold
  function automatic logic [HUE_THR_W-1:0] deg_thr(input logic [DEG_W-1:0] deg);
    deg_thr = {1'b0, deg, 4'b0000};
  endfunction

  // Exact hue > thr, from floor quotient and nonzero remainder
  function automatic logic hue_gt(input logic [QUO_W-1:0] q, input logic rem_nz,
                                  input logic [HUE_THR_W-1:0] thr);
    logic [HUE_THR_W-1:0] qx;
    qx = HUE_THR_W'(q);
    hue_gt = (qx > thr) || ((qx == thr) && rem_nz);
  endfunction

  // Exact hue < thr
  function automatic logic hue_lt(input logic [QUO_W-1:0] q,
                                  input logic [HUE_THR_W-1:0] thr);
    hue_lt = HUE_THR_W'(q) < thr;
  endfunction

endpackage

>>> rtl/core/rhc_in_if.sv
// Input sample channel: valid/ready with the three raw channel readings.
// Depends on rhc_pkg.
interface rhc_in_if import rhc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_red;
  logic [RAW_W-1:0] raw_green;
  logic [RAW_W-1:0] raw_blue;

  modport source (output valid, raw_red, raw_green, raw_blue, input ready);
  modport sink   (input valid, raw_red, raw_green, raw_blue, output ready);
endinterface

>>> rtl/core/rhc_out_if.sv
// Result channel: valid/ready with class, hue, saturation and value.
// Depends on rhc_pkg.
interface rhc_out_if import rhc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CLS_W-1:0] color_class;
  logic [QUO_W-1:0] hue_sixteenths;
  logic [SAT_W-1:0] saturation_q10;
  logic [VAL_W-1:0] value_scaled;

  modport source (output valid, color_class, hue_sixteenths, saturation_q10,
                  value_scaled, input ready);
  modport sink   (input valid, color_class, hue_sixteenths, saturation_q10,
                  value_scaled, output ready);
endinterface

>>> rtl/core/rhc_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on rhc_pkg.
interface rhc_cfg_if import rhc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/rhc_cfg_regs.sv
// Configuration register file for the classifier.
// Depends on rhc_pkg and rhc_cfg_if.
module rhc_cfg_regs import rhc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  rhc_cfg_if.sink       cfg_if,
  output cfg_t          cfg
);

  cfg_t cfg_r, cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_idx_t'(cfg_if.index))
        REG_ARENA_MODE: begin
          cfg_nxt.arena_mode = cfg_if.data[0];
        end
        REG_RGB_GAINS: begin
          cfg_nxt.gain_red   = cfg_if.data[15:0];
          cfg_nxt.gain_green = cfg_if.data[31:16];
          cfg_nxt.gain_blue  = cfg_if.data[47:32];
        end
        REG_WHITE_LIMITS: begin
          cfg_nxt.white_sat_max   = cfg_if.data[10:0];
          cfg_nxt.white_value_min = cfg_if.data[26:11];
        end
        REG_BLACK_VMAX: begin
          cfg_nxt.black_value_max = cfg_if.data[15:0];
        end
        REG_BLACK_VMIN: begin
          cfg_nxt.black_value_min = cfg_if.data[15:0];
        end
        REG_RED_HUE: begin
          cfg_nxt.red_lo = cfg_if.data[8:0];
          cfg_nxt.red_hi = cfg_if.data[17:9];
        end
        REG_GREEN_HUE: begin
          cfg_nxt.green_lo = cfg_if.data[8:0];
          cfg_nxt.green_hi = cfg_if.data[17:9];
        end
        REG_YELLOW_HUE: begin
          cfg_nxt.yellow_lo = cfg_if.data[8:0];
          cfg_nxt.yellow_hi = cfg_if.data[17:9];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/core/rhc_front.sv
// Front end: gain scaling, max/min/sector, hue numerator and divider setup.
// Three register stages. Depends on rhc_pkg.
module rhc_front import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [RAW_W-1:0] raw_red,
  input  logic [RAW_W-1:0] raw_green,
  input  logic [RAW_W-1:0] raw_blue,
  input  cfg_t             cfg,
  output div_stage_t       div_in
);

  // Stage A: scaled channels
  logic                       a_valid_r;
  logic [CH_W-1:0]            a_red_r, a_green_r, a_blue_r;
  logic [RAW_W+GAIN_W-1:0]    prod_red, prod_green, prod_blue;

  // Stage B: value, delta, sector and signed channel difference
  logic                       b_valid_r;
  logic [CH_W-1:0]            b_value_r, b_value_nxt;
  logic [CH_W-1:0]            b_delta_r, b_delta_nxt;
  hue_sector_t                b_sector_r, b_sector_nxt;
  logic signed [CH_W:0]       b_diff_r, b_diff_nxt;
  logic [CH_W-1:0]            min_val;

  // Stage C: divider operands
  div_stage_t                 c_stage_r, c_stage_nxt;
  logic signed [NUM_W-1:0]    diff_x, delta_x, num_s;
  logic [DVD_W-1:0]           num_u, sat_dvd;

  assign prod_red   = (RAW_W+GAIN_W)'(raw_red)   * (RAW_W+GAIN_W)'(cfg.gain_red);
  assign prod_green = (RAW_W+GAIN_W)'(raw_green) * (RAW_W+GAIN_W)'(cfg.gain_green);
  assign prod_blue  = (RAW_W+GAIN_W)'(raw_blue)  * (RAW_W+GAIN_W)'(cfg.gain_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_red_r   <= prod_red[RAW_W+GAIN_W-1:GAIN_FRAC];
      a_green_r <= prod_green[RAW_W+GAIN_W-1:GAIN_FRAC];
      a_blue_r  <= prod_blue[RAW_W+GAIN_W-1:GAIN_FRAC];
    end
  end

  // Red wins ties, then green
  always_comb begin
    b_value_nxt = a_red_r;
    if (a_green_r > b_value_nxt) b_value_nxt = a_green_r;
    if (a_blue_r > b_value_nxt)  b_value_nxt = a_blue_r;
    min_val = a_red_r;
    if (a_green_r < min_val) min_val = a_green_r;
    if (a_blue_r < min_val)  min_val = a_blue_r;
    b_delta_nxt = b_value_nxt - min_val;
    if (a_red_r == b_value_nxt) begin
      b_sector_nxt = SEC_RED;
      b_diff_nxt   = $signed({1'b0, a_green_r}) - $signed({1'b0, a_blue_r});
    end else if (a_green_r == b_value_nxt) begin
      b_sector_nxt = SEC_GREEN;
      b_diff_nxt   = $signed({1'b0, a_blue_r}) - $signed({1'b0, a_red_r});
    end else begin
      b_sector_nxt = SEC_BLUE;
      b_diff_nxt   = $signed({1'b0, a_red_r}) - $signed({1'b0, a_green_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_value_r  <= b_value_nxt;
      b_delta_r  <= b_delta_nxt;
      b_sector_r <= b_sector_nxt;
      b_diff_r   <= b_diff_nxt;
    end
  end

  // Hue numerator in sixteenths of a degree; always lands in 0..5760*delta-1
  always_comb begin
    diff_x  = NUM_W'(b_diff_r);
    delta_x = $signed(NUM_W'(b_delta_r));
    unique case (b_sector_r)
      SEC_RED: begin
        num_s = diff_x * HUE_SPAN;
        if (num_s < 0) num_s = num_s + delta_x * HUE_FULL;
      end
      SEC_GREEN: num_s = diff_x * HUE_SPAN + delta_x * HUE_GREEN_OFS;
      SEC_BLUE:  num_s = diff_x * HUE_SPAN + delta_x * HUE_BLUE_OFS;
      default:   num_s = '0;
    endcase
    num_u   = (b_delta_r == '0) ? '0 : num_s[DVD_W-1:0];
    sat_dvd = DVD_W'({b_delta_r, SAT_FRAC'(0)});

    c_stage_nxt.valid   = b_valid_r;
    c_stage_nxt.value   = b_value_r;
    c_stage_nxt.hue.den = (b_delta_r == '0) ? CH_W'(1) : b_delta_r;
    c_stage_nxt.hue.rem = num_u[DVD_W-1:QUO_W];
    c_stage_nxt.hue.dvd = num_u[QUO_W-1:0];
    c_stage_nxt.hue.quo = '0;
    c_stage_nxt.sat.den = b_value_r;
    c_stage_nxt.sat.rem = sat_dvd[DVD_W-1:QUO_W];
    c_stage_nxt.sat.dvd = sat_dvd[QUO_W-1:0];
    c_stage_nxt.sat.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_stage_r.valid <= 1'b0;
    end else if (en) begin
      c_stage_r <= c_stage_nxt;
    end
  end

  assign div_in = c_stage_r;

endmodule

>>> rtl/core/rhc_div_step.sv
// One registered step of the two-lane restoring divider (hue and
// saturation): one quotient bit per lane. Depends on rhc_pkg.
module rhc_div_step import rhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  div_stage_t d,
  output div_stage_t q
);

  div_stage_t q_r, q_nxt;

  function automatic div_lane_t lane_step(input div_lane_t l);
    logic [CH_W:0] t;
    logic          ge;
    div_lane_t     o;
    t  = {l.rem, l.dvd[QUO_W-1]};
    ge = t >= {1'b0, l.den};
    o.den = l.den;
    o.rem = ge ? CH_W'(t - {1'b0, l.den}) : t[CH_W-1:0];
    o.dvd = {l.dvd[QUO_W-2:0], 1'b0};
    o.quo = {l.quo[QUO_W-2:0], ge};
    lane_step = o;
  endfunction

  always_comb begin
    q_nxt       = d;
    q_nxt.hue   = lane_step(d.hue);
    q_nxt.sat   = lane_step(d.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

>>> rtl/core/rhc_classify.sv
// Classification and output register: thresholds against exact hue and
// saturation from quotient and remainder. Depends on rhc_pkg.
module rhc_classify import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  div_stage_t       d,
  input  cfg_t             cfg,
  output logic             out_valid,
  output logic [CLS_W-1:0] color_class,
  output logic [QUO_W-1:0] hue_sixteenths,
  output logic [SAT_W-1:0] saturation_q10,
  output logic [VAL_W-1:0] value_scaled
);

  logic             valid_r;
  color_class_t     cls_r, cls_nxt;
  logic [QUO_W-1:0] hue_r;
  logic [SAT_W-1:0] sat_r, sat_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;

  logic             rem_nz, white_sat, black_win;
  logic             is_red, is_green, is_yellow;

  always_comb begin
    rem_nz    = d.hue.rem != '0;
    value_nxt = VAL_W'(d.value);
    // divide by zero value: saturation is zero by definition
    sat_nxt   = (d.value == '0) ? '0 : d.sat.quo[SAT_W-1:0];
    // floor(1024*delta/v) < smax  <=>  1024*delta < smax*v
    white_sat = sat_nxt < cfg.white_sat_max;

    black_win = (BLACK_LO_NEG || hue_gt(d.hue.quo, rem_nz, BLACK_THR_LO)) &&
                hue_lt(d.hue.quo, BLACK_THR_HI);
    is_red    = hue_lt(d.hue.quo, deg_thr(cfg.red_lo)) ||
                hue_gt(d.hue.quo, rem_nz, deg_thr(cfg.red_hi));
    is_green  = hue_gt(d.hue.quo, rem_nz, deg_thr(cfg.green_lo)) &&
                hue_lt(d.hue.quo, deg_thr(cfg.green_hi));
    is_yellow = hue_gt(d.hue.quo, rem_nz, deg_thr(cfg.yellow_lo)) &&
                hue_lt(d.hue.quo, deg_thr(cfg.yellow_hi));

    priority if (value_nxt > cfg.white_value_min && white_sat) begin
      cls_nxt = CLS_WHITE;
    end else if (cfg.arena_mode && value_nxt < cfg.black_value_max) begin
      cls_nxt = black_win ? CLS_BLACK : CLS_OUTSIDE;
    end else if (!cfg.arena_mode && value_nxt > cfg.black_value_min &&
                 value_nxt < cfg.black_value_max) begin
      cls_nxt = CLS_BLACK;
    end else if (!cfg.arena_mode && value_nxt < cfg.black_value_min) begin
      cls_nxt = CLS_OUTSIDE;
    end else if (is_red) begin
      cls_nxt = CLS_RED;
    end else if (is_green) begin
      cls_nxt = CLS_GREEN;
    end else if (is_yellow) begin
      cls_nxt = CLS_YELLOW;
    end else begin
      cls_nxt = CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r   <= cls_nxt;
      hue_r   <= d.hue.quo;
      sat_r   <= sat_nxt;
      value_r <= value_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign color_class    = cls_r;
  assign hue_sixteenths = hue_r;
  assign saturation_q10 = sat_r;
  assign value_scaled   = value_r;

endmodule

>>> rtl/core/rgb_hsv_color_classifier_top.sv
// RGB to HSV color classifier, pipelined: a new sample may be transferred
// in every cycle while in_if.ready is high, and its result passes through
// 3 front-end stages for gain scaling, max/min and hue numerator, 13 divider
// steps that produce hue and saturation one quotient bit each, and 1 output stage.
// The whole pipeline advances together: it moves whenever the output
// register is empty or its result is being transferred, so in_if.ready
// drops only while a finished result waits on out_if. Configuration
// writes are always taken and should be made only with the pipeline empty.
// Depends on rhc_pkg, the three channel interfaces and the rhc_* modules.
module rgb_hsv_color_classifier_top import rhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rhc_in_if.sink     in_if,
  rhc_out_if.source  out_if,
  rhc_cfg_if.sink    cfg_if
);

  cfg_t       cfg;
  logic       en;
  logic       out_valid;
  div_stage_t div_pipe [QUO_W+1];

  // Global advance: output slot free or being drained this cycle
  assign en          = !out_valid || out_if.ready;
  assign in_if.ready = en;
  assign out_if.valid = out_valid;

  rhc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Scaling, value/delta, hue numerator; feeds the divider
  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_if.valid),
    .raw_red   (in_if.raw_red),
    .raw_green (in_if.raw_green),
    .raw_blue  (in_if.raw_blue),
    .cfg       (cfg),
    .div_in    (div_pipe[0])
  );

  // Restoring divider, one quotient bit per stage for both lanes.
  // Saturation quotient never exceeds 1024, so its top two bits stay zero.
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    rhc_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (div_pipe[i]),
      .q     (div_pipe[i+1])
    );
  end

  // Class decision and output register
  rhc_classify u_cls (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .d              (div_pipe[QUO_W]),
    .cfg            (cfg),
    .out_valid      (out_valid),
    .color_class    (out_if.color_class),
    .hue_sixteenths (out_if.hue_sixteenths),
    .saturation_q10 (out_if.saturation_q10),
    .value_scaled   (out_if.value_scaled)
  );

endmodule
